// File: design/fte_pkg.sv
// Shared types and constants of the FAT table engine.
package fte_pkg;

    // Default image size in bytes
    localparam int unsigned FAT_BYTES_DEF = 65536;

    // Action codes
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_GET   = 3'd2;
    localparam logic [2:0] ACT_LINK  = 3'd3;
    localparam logic [2:0] ACT_FREE  = 3'd4;
    localparam logic [2:0] ACT_CHAIN = 3'd5;
    localparam logic [2:0] ACT_NTH   = 3'd6;

    // Table formats (anything else is FAT32)
    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    // Entry classes
    localparam logic [1:0] CLS_USED = 2'd0;
    localparam logic [1:0] CLS_FREE = 2'd1;
    localparam logic [1:0] CLS_BAD  = 2'd2;
    localparam logic [1:0] CLS_EOC  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_FREEIN  = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    // Entry masks and markers
    localparam logic [31:0] MASK28      = 32'h0FFF_FFFF;
    localparam logic [31:0] FAT12_MASK  = 32'h0000_0FFF;
    localparam logic [31:0] FAT16_MASK  = 32'h0000_FFFF;
    localparam logic [31:0] LOW_NIBBLE  = 32'h0000_000F;
    localparam logic [31:0] HIGH_NIBBLE = 32'h0000_F000;
    localparam logic [31:0] TOP_FOUR    = 32'hF000_0000;
    localparam logic [31:0] MARK_BAD    = 32'h0FFF_FFF7;
    localparam logic [31:0] MARK_EOC    = 32'h0FFF_FFF8;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_BYTE_RD,
        S_LOOP,
        S_PLACE,
        S_RD_ISSUE,
        S_RD_CAP,
        S_DECIDE,
        S_WR,
        S_FIN
    } state_t;

endpackage

// File: design/fat_table_engine.sv
// FAT table engine top level: request sequencer around the image memory.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  action, byte_address, byte_in, cluster,
//                                         link_value, position, mark_allocated
//  m_       out        m_valid / m_ready  entry_value, byte_out, entry_class, status
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
// One request at a time. Entry access reads its 2 or 4 image bytes one by one,
// each by issue then capture, through the single memory read port, and writes
// back 1 byte per cycle; chain walks and the free scan repeat that per visited
// cluster. A finished result sits in the output register, and the next request
// is taken while it waits. Reset clears control state only; the image holds
// garbage until loaded.
module fat_table_engine #(
    parameter int unsigned FAT_BYTES = fte_pkg::FAT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [15:0] s_byte_address,
    input  logic [7:0]  s_byte_in,
    input  logic [27:0] s_cluster,
    input  logic [27:0] s_link_value,
    input  logic [15:0] s_position,
    input  logic        s_mark_allocated,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [27:0] m_entry_value,
    output logic [7:0]  m_byte_out,
    output logic [1:0]  m_entry_class,
    output logic [2:0]  m_status
);

    localparam int unsigned AW = $clog2(FAT_BYTES);
    localparam logic [31:0] BYTES32 = 32'(FAT_BYTES);

    fte_pkg::state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [16:0] count_reg;

    logic [2:0]  act_reg, act_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  bin_reg, bin_next;
    logic [27:0] cl_reg, cl_next;
    logic [27:0] link_reg, link_next;
    logic [15:0] pos_reg, pos_next;
    logic        mark_reg, mark_next;
    logic [16:0] steps_reg, steps_next;
    logic [16:0] idx_reg, idx_next;
    logic [31:0] off_reg, off_next;
    logic [1:0]  k_reg, k_next;
    logic [7:0]  bytes_reg [4];
    logic [7:0]  bytes_next [4];
    logic [27:0] wval_reg, wval_next;
    logic        done_reg, done_next;

    logic [27:0] rval_reg, rval_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic [1:0]  rcls_reg, rcls_next;
    logic [2:0]  rst_reg, rst_next;

    logic        m_valid_reg;
    logic [27:0] o_value_reg;
    logic [7:0]  o_byte_reg;
    logic [1:0]  o_cls_reg;
    logic [2:0]  o_status_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    fte_ram #(.DEPTH(FAT_BYTES), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // format dependent masks and markers
    logic [31:0] kmask, bad_mark, eoc_mark;
    logic        wide;
    always_comb begin
        unique case (kind_reg)
            fte_pkg::KIND_FAT12: kmask = fte_pkg::FAT12_MASK;
            fte_pkg::KIND_FAT16: kmask = fte_pkg::FAT16_MASK;
            default:             kmask = fte_pkg::MASK28;
        endcase
        bad_mark = fte_pkg::MARK_BAD & kmask;
        eoc_mark = fte_pkg::MARK_EOC & kmask;
        wide = (kind_reg != fte_pkg::KIND_FAT12) && (kind_reg != fte_pkg::KIND_FAT16);
    end

    // entry placement of the current cluster
    logic [31:0] place_off;
    logic        place_ok;
    always_comb begin
        unique case (kind_reg)
            fte_pkg::KIND_FAT12: place_off = {4'd0, cl_reg} + {5'd0, cl_reg[27:1]};
            fte_pkg::KIND_FAT16: place_off = {3'd0, cl_reg, 1'b0};
            default:             place_off = {2'd0, cl_reg, 2'b00};
        endcase
        place_ok = (place_off + (wide ? 32'd4 : 32'd2)) <= BYTES32;
    end

    // raw entry assembled from the fetched bytes
    logic [31:0] pair, raw, raw28, mraw;
    logic        is_free, is_bad, is_eoc;
    always_comb begin
        pair = {16'd0, bytes_reg[1], bytes_reg[0]};
        if (kind_reg == fte_pkg::KIND_FAT12) begin
            raw = cl_reg[0] ? (pair >> 4) : (pair & fte_pkg::FAT12_MASK);
        end else if (kind_reg == fte_pkg::KIND_FAT16) begin
            raw = pair;
        end else begin
            raw = {bytes_reg[3], bytes_reg[2], bytes_reg[1], bytes_reg[0]};
        end
        raw28   = raw & fte_pkg::MASK28;
        mraw    = raw & kmask;
        is_free = (mraw == 32'd0);
        is_bad  = (mraw == bad_mark);
        is_eoc  = (mraw >= eoc_mark);
    end

    // word written back for a link update
    logic [31:0] new_word, to32, old32;
    always_comb begin
        to32  = {4'd0, wval_reg};
        old32 = {bytes_reg[3], bytes_reg[2], bytes_reg[1], bytes_reg[0]};
        if (kind_reg == fte_pkg::KIND_FAT12) begin
            if (cl_reg[0]) begin
                new_word = ((pair & fte_pkg::LOW_NIBBLE) | (to32 << 4)) & fte_pkg::FAT16_MASK;
            end else begin
                new_word = (pair & fte_pkg::HIGH_NIBBLE) | (to32 & fte_pkg::FAT12_MASK);
            end
        end else if (kind_reg == fte_pkg::KIND_FAT16) begin
            new_word = to32 & fte_pkg::FAT16_MASK;
        end else begin
            new_word = (old32 & fte_pkg::TOP_FOUR) | (to32 & fte_pkg::MASK28);
        end
    end

    logic [1:0]  k_last;
    logic [31:0] byte_pos, addr32;
    logic        addr_ok;
    assign k_last   = wide ? 2'd3 : 2'd1;
    assign byte_pos = off_reg + {30'd0, k_reg};
    assign addr32   = {16'd0, addr_reg};
    assign addr_ok  = addr32 < BYTES32;

    assign s_ready = (state_reg == fte_pkg::S_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        addr_next  = addr_reg;
        bin_next   = bin_reg;
        cl_next    = cl_reg;
        link_next  = link_reg;
        pos_next   = pos_reg;
        mark_next  = mark_reg;
        steps_next = steps_reg;
        idx_next   = idx_reg;
        off_next   = off_reg;
        k_next     = k_reg;
        for (int i = 0; i < 4; i++) bytes_next[i] = bytes_reg[i];
        wval_next  = wval_reg;
        done_next  = done_reg;
        rval_next  = rval_reg;
        rbyte_next = rbyte_reg;
        rcls_next  = rcls_reg;
        rst_next   = rst_reg;
        ram_we     = 1'b0;
        ram_waddr  = byte_pos[AW-1:0];
        ram_wdata  = new_word[8*k_reg +: 8];
        ram_raddr  = byte_pos[AW-1:0];

        unique case (state_reg)
            fte_pkg::S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    addr_next  = s_byte_address;
                    bin_next   = s_byte_in;
                    cl_next    = s_cluster;
                    link_next  = s_link_value;
                    pos_next   = s_position;
                    mark_next  = s_mark_allocated;
                    rval_next  = '0;
                    rbyte_next = '0;
                    rcls_next  = fte_pkg::CLS_USED;
                    rst_next   = fte_pkg::ST_OK;
                    state_next = fte_pkg::S_DISPATCH;
                end
            end
            fte_pkg::S_DISPATCH: begin
                steps_next = '0;
                idx_next   = '0;
                case (act_reg)
                    fte_pkg::ACT_LOAD: begin
                        ram_waddr = addr32[AW-1:0];
                        ram_wdata = bin_reg;
                        if (addr_ok) ram_we = 1'b1;
                        else rst_next = fte_pkg::ST_RANGE;
                        state_next = fte_pkg::S_FIN;
                    end
                    fte_pkg::ACT_READ: begin
                        ram_raddr = addr32[AW-1:0];
                        if (addr_ok) begin
                            state_next = fte_pkg::S_BYTE_RD;
                        end else begin
                            rst_next   = fte_pkg::ST_RANGE;
                            state_next = fte_pkg::S_FIN;
                        end
                    end
                    fte_pkg::ACT_GET, fte_pkg::ACT_LINK, fte_pkg::ACT_CHAIN,
                    fte_pkg::ACT_NTH: begin
                        state_next = fte_pkg::S_LOOP;
                    end
                    fte_pkg::ACT_FREE: begin
                        cl_next    = 28'd2;
                        state_next = fte_pkg::S_LOOP;
                    end
                    default: begin
                        rst_next   = fte_pkg::ST_RANGE;
                        state_next = fte_pkg::S_FIN;
                    end
                endcase
            end
            fte_pkg::S_BYTE_RD: begin
                rbyte_next = ram_rdata;
                state_next = fte_pkg::S_FIN;
            end
            // per visit limit checks
            fte_pkg::S_LOOP: begin
                state_next = fte_pkg::S_PLACE;
                if (act_reg == fte_pkg::ACT_FREE) begin
                    if (cl_reg >= {11'd0, count_reg}) begin
                        rst_next   = fte_pkg::ST_NONE;
                        state_next = fte_pkg::S_FIN;
                    end
                end else if (act_reg == fte_pkg::ACT_CHAIN || act_reg == fte_pkg::ACT_NTH) begin
                    if (steps_reg >= count_reg) begin
                        rst_next   = fte_pkg::ST_RANGE;
                        state_next = fte_pkg::S_FIN;
                    end else begin
                        steps_next = steps_reg + 17'd1;
                    end
                end
            end
            fte_pkg::S_PLACE: begin
                off_next = place_off;
                k_next   = '0;
                if (place_ok) begin
                    state_next = fte_pkg::S_RD_ISSUE;
                end else begin
                    rst_next   = (act_reg == fte_pkg::ACT_FREE) ? fte_pkg::ST_NONE
                                                               : fte_pkg::ST_RANGE;
                    state_next = fte_pkg::S_FIN;
                end
            end
            fte_pkg::S_RD_ISSUE: begin
                state_next = fte_pkg::S_RD_CAP;
            end
            fte_pkg::S_RD_CAP: begin
                bytes_next[k_reg] = ram_rdata;
                if (k_reg == k_last) begin
                    state_next = fte_pkg::S_DECIDE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = fte_pkg::S_RD_ISSUE;
                end
            end
            // act on the fetched entry
            fte_pkg::S_DECIDE: begin
                k_next = '0;
                case (act_reg)
                    fte_pkg::ACT_GET: begin
                        rval_next = raw28[27:0];
                        if (is_free)     rcls_next = fte_pkg::CLS_FREE;
                        else if (is_bad) rcls_next = fte_pkg::CLS_BAD;
                        else if (is_eoc) rcls_next = fte_pkg::CLS_EOC;
                        else             rcls_next = fte_pkg::CLS_USED;
                        state_next = fte_pkg::S_FIN;
                    end
                    fte_pkg::ACT_LINK: begin
                        wval_next  = link_reg;
                        done_next  = 1'b1;
                        state_next = fte_pkg::S_WR;
                    end
                    fte_pkg::ACT_FREE: begin
                        if (is_free) begin
                            rval_next  = cl_reg;
                            wval_next  = eoc_mark[27:0];
                            done_next  = 1'b1;
                            state_next = mark_reg ? fte_pkg::S_WR : fte_pkg::S_FIN;
                        end else begin
                            cl_next    = cl_reg + 28'd1;
                            state_next = fte_pkg::S_LOOP;
                        end
                    end
                    fte_pkg::ACT_CHAIN: begin
                        wval_next  = '0;
                        done_next  = is_eoc;
                        link_next  = raw28[27:0];
                        state_next = fte_pkg::S_WR;
                    end
                    default: begin
                        // nth of chain
                        state_next = fte_pkg::S_FIN;
                        if (is_bad) begin
                            rst_next = fte_pkg::ST_BAD;
                        end else if (is_free) begin
                            rst_next = fte_pkg::ST_FREEIN;
                        end else if (idx_reg == {1'b0, pos_reg}) begin
                            rval_next = cl_reg;
                        end else if (is_eoc) begin
                            rst_next = fte_pkg::ST_NONE;
                        end else begin
                            cl_next    = raw28[27:0];
                            idx_next   = idx_reg + 17'd1;
                            state_next = fte_pkg::S_LOOP;
                        end
                    end
                endcase
            end
            // write back one byte per cycle
            fte_pkg::S_WR: begin
                ram_we = 1'b1;
                if (k_reg == k_last) begin
                    if (done_reg) begin
                        state_next = fte_pkg::S_FIN;
                    end else begin
                        cl_next    = link_reg;
                        state_next = fte_pkg::S_LOOP;
                    end
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
            fte_pkg::S_FIN: begin
                if (!m_valid_reg || m_ready) state_next = fte_pkg::S_IDLE;
            end
            default: state_next = fte_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fte_pkg::S_IDLE;
            kind_reg    <= fte_pkg::KIND_FAT32;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    fte_pkg::CFG_KIND:  kind_reg  <= cfg_data[1:0];
                    fte_pkg::CFG_COUNT: count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == fte_pkg::S_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        addr_reg  <= addr_next;
        bin_reg   <= bin_next;
        cl_reg    <= cl_next;
        link_reg  <= link_next;
        pos_reg   <= pos_next;
        mark_reg  <= mark_next;
        steps_reg <= steps_next;
        idx_reg   <= idx_next;
        off_reg   <= off_next;
        k_reg     <= k_next;
        for (int i = 0; i < 4; i++) bytes_reg[i] <= bytes_next[i];
        wval_reg  <= wval_next;
        done_reg  <= done_next;
        rval_reg  <= rval_next;
        rbyte_reg <= rbyte_next;
        rcls_reg  <= rcls_next;
        rst_reg   <= rst_next;
        if (state_reg == fte_pkg::S_FIN && (!m_valid_reg || m_ready)) begin
            o_value_reg  <= rval_reg;
            o_byte_reg   <= rbyte_reg;
            o_cls_reg    <= rcls_reg;
            o_status_reg <= rst_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_value = o_value_reg;
    assign m_byte_out    = o_byte_reg;
    assign m_entry_class = o_cls_reg;
    assign m_status      = o_status_reg;

    // checks
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fte_pkg::S_IDLE) |-> !ram_we)
        else $error("image write while idle");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == fte_pkg::S_DISPATCH))
        else $error("accepted request not dispatched");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fte_pkg::S_FIN))
        else $error("result raised outside finish");

endmodule

// File: design/fte_ram.sv
// Byte-wide image memory: one write port, one registered read port.
module fte_ram #(
    parameter int unsigned DEPTH = fte_pkg::FAT_BYTES_DEF,
    parameter int unsigned AW    = $clog2(fte_pkg::FAT_BYTES_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
